// ===== src/rpsfa_pkg.sv =====
// Shared types and constants for the RDS PS frame assembler.
package rpsfa_pkg;

    localparam int NUM_PAIRS = 4;
    localparam int IN_TDATA_W = 40;
    localparam int OUT_TDATA_W = 72;

    localparam logic [3:0] GROUP_TYPE_0 = 4'h0;
    localparam logic [7:0] CHAR_BLANK = 8'h20;
    localparam logic [7:0] CHAR_DEL = 8'h7F;

    localparam logic ACT_GROUP = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    localparam logic [1:0] MAX_ERR_RESET = 2'd1;

    typedef struct packed {
        logic        action;
        logic        new_group;
        logic [1:0]  error_level_a;
        logic [1:0]  error_level_b;
        logic [15:0] block_b_word;
        logic [15:0] block_d_word;
    } item_t;

    typedef struct packed {
        logic [63:0] frame_text;
        logic        frame_dropped;
        logic        frame_valid;
        logic        group_accepted;
    } result_t;

endpackage

// ===== src/rpsfa_store.sv =====
// Character pair store, wave tracking and frame checks for one item.
module rpsfa_store
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  rpsfa_pkg::item_t  item,
    input  logic [1:0]        max_error_level,
    output rpsfa_pkg::result_t result
);

    logic [15:0] chars_reg [rpsfa_pkg::NUM_PAIRS];
    logic [15:0] chars_next [rpsfa_pkg::NUM_PAIRS];
    logic [rpsfa_pkg::NUM_PAIRS-1:0] ever_reg;
    logic [rpsfa_pkg::NUM_PAIRS-1:0] ever_next;
    logic [rpsfa_pkg::NUM_PAIRS-1:0] seen_reg;
    logic [rpsfa_pkg::NUM_PAIRS-1:0] seen_next;

    logic        accept;
    logic [1:0]  pos;
    logic        restart;
    logic [rpsfa_pkg::NUM_PAIRS-1:0] pos_mask;
    logic [rpsfa_pkg::NUM_PAIRS-1:0] seen_upd;
    logic [15:0] chars_upd [rpsfa_pkg::NUM_PAIRS];
    logic        full;
    logic        printable;
    logic        nonblank;
    logic [63:0] text;

    assign pos = item.block_b_word[1:0];
    assign pos_mask = rpsfa_pkg::NUM_PAIRS'(1) << pos;

    assign accept = (item.action == rpsfa_pkg::ACT_GROUP) && item.new_group
                    && (item.error_level_a <= max_error_level)
                    && (item.error_level_b <= max_error_level)
                    && (item.block_b_word[15:12] == rpsfa_pkg::GROUP_TYPE_0);

    assign restart = ever_reg[pos] && seen_reg[pos]
                     && (chars_reg[pos] != item.block_d_word);

    assign seen_upd = (restart ? '0 : seen_reg) | pos_mask;
    assign full = &seen_upd;

    always_comb
    begin
        printable = 1'b1;
        nonblank = 1'b0;
        for (int i = 0; i < rpsfa_pkg::NUM_PAIRS; i++)
        begin
            chars_upd[i] = (pos == 2'(i)) ? item.block_d_word : chars_reg[i];
            if (chars_upd[i][15:8] < rpsfa_pkg::CHAR_BLANK
                || chars_upd[i][15:8] >= rpsfa_pkg::CHAR_DEL
                || chars_upd[i][7:0] < rpsfa_pkg::CHAR_BLANK
                || chars_upd[i][7:0] >= rpsfa_pkg::CHAR_DEL)
            begin
                printable = 1'b0;
            end
            if (chars_upd[i][15:8] != rpsfa_pkg::CHAR_BLANK
                || chars_upd[i][7:0] != rpsfa_pkg::CHAR_BLANK)
            begin
                nonblank = 1'b1;
            end
        end
    end

    // first pair lands in the top bytes
    assign text = {chars_upd[0], chars_upd[1], chars_upd[2], chars_upd[3]};

    always_comb
    begin
        result.group_accepted = accept;
        result.frame_valid = accept && full && printable && nonblank;
        result.frame_dropped = accept && full && !(printable && nonblank);
        result.frame_text = (accept && full) ? text : 64'd0;
    end

    always_comb
    begin
        ever_next = ever_reg;
        seen_next = seen_reg;
        for (int i = 0; i < rpsfa_pkg::NUM_PAIRS; i++)
        begin
            chars_next[i] = chars_reg[i];
        end
        if (fire)
        begin
            if (item.action == rpsfa_pkg::ACT_CLEAR)
            begin
                ever_next = '0;
                seen_next = '0;
                for (int i = 0; i < rpsfa_pkg::NUM_PAIRS; i++)
                begin
                    chars_next[i] = 16'd0;
                end
            end
            else if (accept)
            begin
                ever_next = ever_reg | pos_mask;
                seen_next = seen_upd;
                for (int i = 0; i < rpsfa_pkg::NUM_PAIRS; i++)
                begin
                    chars_next[i] = chars_upd[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ever_reg <= '0;
            seen_reg <= '0;
            for (int i = 0; i < rpsfa_pkg::NUM_PAIRS; i++)
            begin
                chars_reg[i] <= 16'd0;
            end
        end
        else
        begin
            ever_reg <= ever_next;
            seen_reg <= seen_next;
            for (int i = 0; i < rpsfa_pkg::NUM_PAIRS; i++)
            begin
                chars_reg[i] <= chars_next[i];
            end
        end
    end

endmodule

// ===== src/rds_ps_frame_assembler.sv =====
// An accepted item is held in the input register, then its result in the output register, before it shows on m_axis.
// One item per cycle while m_axis_tready is high; the input register still takes one item while the result waits.
// The store update and frame checks are combinational between the input and result registers.
// Reset: rst_n clears the pair store, wave marks and valid flags; max_error_level goes to 1.
// Top level: item stream in, frame result stream out, APB register port.
module rds_ps_frame_assembler
(
    input  logic        clk,
    input  logic        rst_n,
    // APB
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // item in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // new_group[0], error_level_a[2:1], error_level_b[4:3],
    // block_b_word[20:5], block_d_word[36:21], zero pad[39:37]
    input  logic [rpsfa_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // action[0]
    input  logic        s_axis_tuser,
    // result out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // group_accepted[0], frame_valid[1], frame_dropped[2],
    // frame_text[66:3], zero pad[71:67]
    output logic [rpsfa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [1:0]         max_err_reg;
    logic               in_valid_reg;
    rpsfa_pkg::item_t   in_item_reg;
    logic               out_valid_reg;
    rpsfa_pkg::result_t out_res_reg;
    rpsfa_pkg::result_t res;
    logic               advance;
    logic               in_fire;

    assign pready = 1'b1;
    assign prdata = {30'd0, max_err_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_err_reg <= rpsfa_pkg::MAX_ERR_RESET;
        end
        else if (psel && penable && pwrite && pready && !paddr[2])
        begin
            max_err_reg <= pwdata[1:0];
        end
    end

    assign advance = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_item_reg.action <= s_axis_tuser;
            in_item_reg.new_group <= s_axis_tdata[0];
            in_item_reg.error_level_a <= s_axis_tdata[2:1];
            in_item_reg.error_level_b <= s_axis_tdata[4:3];
            in_item_reg.block_b_word <= s_axis_tdata[20:5];
            in_item_reg.block_d_word <= s_axis_tdata[36:21];
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    rpsfa_store u_store
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (advance),
        .item            (in_item_reg),
        .max_error_level (max_err_reg),
        .result          (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {5'd0, out_res_reg.frame_text, out_res_reg.frame_dropped,
                           out_res_reg.frame_valid, out_res_reg.group_accepted};

endmodule

// ===== src/rpsfa_checker.sv =====
// Port-level checks for the RDS PS frame assembler, bound to the top level.
module rpsfa_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [rpsfa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[2]))
        else $error("frame both presented and dropped");

    // rejected or cleared: all zero
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[66:1] == 66'd0)
        else $error("rejected item carries data");

    a_valid_nonblank: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[66:3] != 64'h2020202020202020)
        else $error("blank frame presented");

endmodule

bind rds_ps_frame_assembler rpsfa_checker u_rpsfa_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/rds_ps_frame_checker.sv =====
`timescale 1ns / 1ps
// Checker for the RDS PS frame assembler: predicts each item's result and compares it.
module rds_ps_frame_checker
#(
    parameter logic [2:0] ERR_LIMIT_ADDR = 3'd0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [rpsfa_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [rpsfa_pkg::OUT_TDATA_W-1:0] m_tdata,
    output int                    mismatches,
    output int                    items_pending
);

    logic [15:0]          pair_store [rpsfa_pkg::NUM_PAIRS];
    logic [rpsfa_pkg::NUM_PAIRS-1:0] pair_heard;
    logic [rpsfa_pkg::NUM_PAIRS-1:0] pair_in_wave;
    logic [1:0]           err_limit;
    rpsfa_pkg::result_t   frames_due [$];
    rpsfa_pkg::result_t   got;
    rpsfa_pkg::result_t   want;
    rpsfa_pkg::item_t     offered;

    initial mismatches = 0;

    task automatic report_mismatch(string field, logic [63:0] seen, logic [63:0] wanted);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, field, seen, wanted);
        mismatches++;
    endtask

    function automatic void wipe_store();
        for (int i = 0; i < rpsfa_pkg::NUM_PAIRS; i++)
            pair_store[i] = '0;
        pair_heard = '0;
        pair_in_wave = '0;
    endfunction

    function automatic rpsfa_pkg::result_t assemble_group(rpsfa_pkg::item_t it);
        rpsfa_pkg::result_t res;
        logic [1:0]   pos;
        logic [63:0]  text;
        logic [7:0]   hi;
        logic [7:0]   lo;
        logic         printable;
        logic         nonblank;
        res = '0;
        text = '0;
        printable = 1'b1;
        nonblank = 1'b0;
        if (it.action == rpsfa_pkg::ACT_CLEAR)
        begin
            wipe_store();
            return res;
        end
        if (!it.new_group || it.error_level_a > err_limit || it.error_level_b > err_limit
            || it.block_b_word[15:12] != rpsfa_pkg::GROUP_TYPE_0)
            return res;
        res.group_accepted = 1'b1;
        pos = it.block_b_word[1:0];
        // changed pair at a position already seen restarts the wave
        if (pair_heard[pos] && pair_in_wave[pos] && pair_store[pos] != it.block_d_word)
            pair_in_wave = '0;
        pair_store[pos] = it.block_d_word;
        pair_heard[pos] = 1'b1;
        pair_in_wave[pos] = 1'b1;
        if (!(&pair_in_wave))
            return res;
        for (int i = 0; i < rpsfa_pkg::NUM_PAIRS; i++)
        begin
            hi = pair_store[i][15:8];
            lo = pair_store[i][7:0];
            text = {text[47:0], pair_store[i]};
            if (hi < rpsfa_pkg::CHAR_BLANK || hi >= rpsfa_pkg::CHAR_DEL
                || lo < rpsfa_pkg::CHAR_BLANK || lo >= rpsfa_pkg::CHAR_DEL)
                printable = 1'b0;
            if (hi != rpsfa_pkg::CHAR_BLANK || lo != rpsfa_pkg::CHAR_BLANK)
                nonblank = 1'b1;
        end
        res.frame_text = text;
        if (printable && nonblank)
            res.frame_valid = 1'b1;
        else
            res.frame_dropped = 1'b1;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_store();
            err_limit = rpsfa_pkg::MAX_ERR_RESET;
            frames_due.delete();
            items_pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ERR_LIMIT_ADDR)
                err_limit = pwdata[1:0];
            if (s_tvalid && s_tready)
            begin
                offered.action        = s_tuser;
                offered.new_group     = s_tdata[0];
                offered.error_level_a = s_tdata[2:1];
                offered.error_level_b = s_tdata[4:3];
                offered.block_b_word  = s_tdata[20:5];
                offered.block_d_word  = s_tdata[36:21];
                frames_due.push_back(assemble_group(offered));
            end
            if (m_tvalid && m_tready)
            begin
                got.group_accepted = m_tdata[0];
                got.frame_valid    = m_tdata[1];
                got.frame_dropped  = m_tdata[2];
                got.frame_text     = m_tdata[66:3];
                if (frames_due.size() == 0)
                    report_mismatch("result with no item pending", got.frame_text, 64'h0);
                else
                begin
                    want = frames_due.pop_front();
                    if (got.group_accepted !== want.group_accepted)
                        report_mismatch("group_accepted", 64'(got.group_accepted),
                                        64'(want.group_accepted));
                    if (got.frame_valid !== want.frame_valid)
                        report_mismatch("frame_valid", 64'(got.frame_valid),
                                        64'(want.frame_valid));
                    if (got.frame_dropped !== want.frame_dropped)
                        report_mismatch("frame_dropped", 64'(got.frame_dropped),
                                        64'(want.frame_dropped));
                    if (got.frame_text !== want.frame_text)
                        report_mismatch("frame_text", got.frame_text, want.frame_text);
                end
            end
            items_pending <= frames_due.size();
        end
    end

endmodule

// ===== bench/rds_ps_frame_assembler_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the RDS PS frame assembler: clock, reset, stimulus and verdict.
module rds_ps_frame_assembler_tb;

    localparam logic [2:0] ERR_LIMIT_ADDR = 3'd0;
    localparam int STALL_LIMIT = 2000;
    localparam int ITEMS_PER_SETTING = 250;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [2:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [rpsfa_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [rpsfa_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    int         mismatches;
    int         items_pending;
    int         stall_cycles = 0;
    int         tx_idle_pct = 31;
    int         rx_idle_pct = 47;
    int         err_cap = int'(rpsfa_pkg::MAX_ERR_RESET);
    logic [15:0] station [rpsfa_pkg::NUM_PAIRS];

    always #5 clk = ~clk;

    rds_ps_frame_assembler u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rds_ps_frame_checker #(.ERR_LIMIT_ADDR(ERR_LIMIT_ADDR)) u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_tvalid      (s_axis_tvalid),
        .s_tready      (s_axis_tready),
        .s_tdata       (s_axis_tdata),
        .s_tuser       (s_axis_tuser),
        .m_tvalid      (m_axis_tvalid),
        .m_tready      (m_axis_tready),
        .m_tdata       (m_axis_tdata),
        .mismatches    (mismatches),
        .items_pending (items_pending)
    );

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic rpsfa_pkg::item_t make_item(logic act, logic ng, logic [1:0] ea,
                                                   logic [1:0] eb, logic [15:0] bw,
                                                   logic [15:0] dw);
        rpsfa_pkg::item_t it;
        it.action        = act;
        it.new_group     = ng;
        it.error_level_a = ea;
        it.error_level_b = eb;
        it.block_b_word  = bw;
        it.block_d_word  = dw;
        return it;
    endfunction

    function automatic logic [7:0] rand_char();
        int r;
        r = $urandom_range(99);
        if (r < 85)
            return 8'($urandom_range(8'h7E, 8'h20));
        if (r < 90)
            return rpsfa_pkg::CHAR_BLANK;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_item(rpsfa_pkg::item_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.action;
        s_axis_tdata  <= {3'b000, it.block_d_word, it.block_b_word, it.error_level_b,
                          it.error_level_a, it.new_group};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_group(logic ng, logic [1:0] ea, logic [1:0] eb, logic [15:0] bw,
                              logic [15:0] dw);
        send_item(make_item(rpsfa_pkg::ACT_GROUP, ng, ea, eb, bw, dw));
    endtask

    task automatic send_clear();
        send_item(make_item(rpsfa_pkg::ACT_CLEAR, 1'b0, 2'd0, 2'd0, 16'h0000, 16'h0000));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (items_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_err_limit(logic [1:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ERR_LIMIT_ADDR;
        pwdata  <= {30'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        err_cap = int'(value);
    endtask

    task automatic new_station();
        logic all_blank;
        all_blank = ($urandom_range(99) < 5);
        for (int i = 0; i < rpsfa_pkg::NUM_PAIRS; i++)
            station[i] = all_blank ? {rpsfa_pkg::CHAR_BLANK, rpsfa_pkg::CHAR_BLANK}
                                   : {rand_char(), rand_char()};
    endtask

    task automatic run_random(int count);
        int         pick;
        logic [1:0] pos;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
                send_clear();
            else if (pick < 15)
                send_item(make_item(rpsfa_pkg::ACT_GROUP, 1'($urandom), 2'($urandom),
                                    2'($urandom), 16'($urandom), 16'($urandom)));
            else
            begin
                if ($urandom_range(99) < 8)
                    new_station();
                pos = 2'($urandom);
                if ($urandom_range(99) < 6)
                    station[pos] = {rand_char(), rand_char()};
                send_group(1'b1, 2'($urandom_range(err_cap)), 2'($urandom_range(err_cap)),
                           {rpsfa_pkg::GROUP_TYPE_0, 10'($urandom), pos}, station[pos]);
            end
        end
    endtask

    initial
    begin
        int tx_plan [3];
        int rx_plan [3];
        int limit_plan [6];
        tx_plan = '{31, 47, 0};
        rx_plan = '{47, 31, 0};
        limit_plan = '{0, 3, 2, 1, 3, 0};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, error limit at its reset value
        send_clear();
        send_group(1'b1, 2'd0, 2'd0, 16'h0000, 16'h4142);
        send_group(1'b1, 2'd1, 2'd1, 16'h0FFD, 16'h4344);
        send_group(1'b1, 2'd2, 2'd0, 16'h0002, 16'h4546);
        send_group(1'b1, 2'd0, 2'd3, 16'h0002, 16'h4546);
        send_group(1'b0, 2'd0, 2'd0, 16'h0002, 16'h4546);
        send_group(1'b1, 2'd0, 2'd0, 16'hF002, 16'h4546);
        send_group(1'b1, 2'd0, 2'd0, 16'h1002, 16'h4546);
        send_group(1'b1, 2'd0, 2'd0, 16'h0002, 16'h4546);
        send_group(1'b1, 2'd1, 2'd0, 16'h0003, 16'h4748);
        // repeats of unchanged pairs keep the wave complete
        send_group(1'b1, 2'd0, 2'd0, 16'h0003, 16'h4748);
        send_group(1'b1, 2'd0, 2'd1, 16'h0001, 16'h4344);
        // changed pair restarts the wave
        send_group(1'b1, 2'd0, 2'd0, 16'h0000, 16'h5A5A);
        send_clear();
        // all-blank frame
        send_group(1'b1, 2'd0, 2'd0, 16'h0000, 16'h2020);
        send_group(1'b1, 2'd0, 2'd0, 16'h0001, 16'h2020);
        send_group(1'b1, 2'd0, 2'd0, 16'h0002, 16'h2020);
        send_group(1'b1, 2'd0, 2'd0, 16'h0003, 16'h2020);
        // printable range edges
        send_group(1'b1, 2'd0, 2'd0, 16'h0000, 16'h7E20);
        send_group(1'b1, 2'd0, 2'd0, 16'h0001, 16'h207E);
        send_group(1'b1, 2'd0, 2'd0, 16'h0002, 16'h2020);
        send_group(1'b1, 2'd0, 2'd0, 16'h0003, 16'h2020);
        send_clear();
        // just outside the printable range
        send_group(1'b1, 2'd0, 2'd0, 16'h0000, 16'h417F);
        send_group(1'b1, 2'd0, 2'd0, 16'h0001, 16'h1F41);
        send_group(1'b1, 2'd0, 2'd0, 16'h0002, 16'hFF00);
        send_group(1'b1, 2'd0, 2'd0, 16'h0003, 16'h4142);

        new_station();
        for (int p = 0; p < 3; p++)
        begin
            tx_idle_pct = tx_plan[p];
            rx_idle_pct = rx_plan[p];
            for (int s = 0; s < 2; s++)
            begin
                write_err_limit(2'(limit_plan[2 * p + s]));
                run_random(ITEMS_PER_SETTING);
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/rpsfa_pkg.sv
src/rpsfa_store.sv
src/rds_ps_frame_assembler.sv
src/rpsfa_checker.sv
bench/rds_ps_frame_checker.sv
bench/rds_ps_frame_assembler_tb.sv
